// ===== hw/rtl/f32rem_pkg.sv =====
// ----------------------------------------------------------------------------
// f32rem_pkg
// Shared types and constants for the binary32 remainder core.
// ----------------------------------------------------------------------------
package f32rem_pkg;

    localparam logic [31:0] NAN_PATTERN = 32'h7FFF_FFFF;
    localparam logic [7:0]  EXP_ONES    = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNPACK,
        ST_STEP,
        ST_NORM,
        ST_PACK,
        ST_OUT
    } f32rem_state_t;

    typedef struct packed {
        logic load;
        logic unpack;
        logic step;
        logic norm;
        logic pack;
    } f32rem_cmd_t;

    typedef struct packed {
        logic early;    // result settled before iteration
        logic done;     // iteration finished (exact zero or exponents met)
        logic norm_done;
    } f32rem_status_t;

endpackage

// ===== hw/rtl/f32rem_stream_if.sv =====
// ----------------------------------------------------------------------------
// f32rem_stream_if
// Valid/ready channel carrying a payload of configurable width.
// ----------------------------------------------------------------------------
interface f32rem_stream_if #(
    parameter int Width = 32
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/f32rem_datapath.sv =====
// ----------------------------------------------------------------------------
// f32rem_datapath
// Operand registers, special-case check, shift-subtract loop, renormalise
// and pack.
// ----------------------------------------------------------------------------
module f32rem_datapath
    import f32rem_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  f32rem_cmd_t    cmd,
    input  logic [31:0]    dividend_bits,
    input  logic [31:0]    divisor_bits,
    output f32rem_status_t status,
    output logic [31:0]    result
);

    logic [31:0] x_reg, y_reg;
    logic [24:0] mx_reg, mx_next;
    logic [23:0] my_reg;
    logic signed [9:0] ex_reg, ex_next, ey_reg;
    logic        zero_reg, zero_next;
    logic [31:0] res_reg;

    logic [31:0] xm, ym;
    logic [7:0]  exf, eyf;
    logic        early;
    logic [31:0] early_val;
    logic [23:0] ux_m, uy_m;
    logic signed [9:0] ux_e, uy_e;
    logic [25:0] t;
    logic        ge;

    assign xm  = {x_reg[30:0], 1'b0};
    assign ym  = {y_reg[30:0], 1'b0};
    assign exf = x_reg[30:23];
    assign eyf = y_reg[30:23];

    always_comb
    begin
        early     = 1'b1;
        early_val = NAN_PATTERN;
        if (ym == 32'd0 || eyf == EXP_ONES || exf == EXP_ONES)
            early_val = NAN_PATTERN;
        else if (xm == ym)
            early_val = {x_reg[31], 31'd0};
        else if (xm < ym)
            early_val = x_reg;
        else
            early = 1'b0;
    end

    function automatic logic [33:0] unpack(input logic [31:0] b);
        logic [23:0] m;
        logic [9:0]  e;
        logic [4:0]  z;
        begin
            m = {1'b1, b[22:0]};
            e = {2'b00, b[30:23]};
            z = 5'd22;
            if (b[30:23] == 8'd0)
            begin
                for (int i = 0; i < 23; i++)
                    if (b[i])
                        z = 5'(22 - i);
                m = 24'({b[22:0], 1'b0} << z);
                e = -10'(z);
            end
            unpack = {e, m};
        end
    endfunction

    assign {ux_e, ux_m} = unpack(x_reg);
    assign {uy_e, uy_m} = unpack(y_reg);

    assign t  = {1'b0, mx_reg} - {2'b00, my_reg};
    assign ge = ~t[25];

    // unpack, subtract step; norm shifts left one bit per cycle until bit 23 is set
    always_comb
    begin
        mx_next   = mx_reg;
        ex_next   = ex_reg;
        zero_next = zero_reg;
        if (cmd.unpack)
        begin
            mx_next   = {1'b0, ux_m};
            ex_next   = ux_e;
            zero_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (ge && t == 26'd0)
                zero_next = 1'b1;
            else if (ex_reg > ey_reg)
            begin
                mx_next = ge ? {t[23:0], 1'b0} : {mx_reg[23:0], 1'b0};
                ex_next = ex_reg - 10'sd1;
            end
            else if (ge)
                mx_next = t[24:0];
        end
        else if (cmd.norm && !mx_reg[23])
        begin
            mx_next = {mx_reg[23:0], 1'b0};
            ex_next = ex_reg - 10'sd1;
        end
    end

    // step finishes when exact zero, or exponents met (final subtract done)
    logic last_step_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_step_reg <= 1'b0;
        else if (cmd.unpack)
            last_step_reg <= 1'b0;
        else if (cmd.step && ex_reg <= ey_reg)
            last_step_reg <= 1'b1;
    end

    assign status.early     = early;
    assign status.done      = zero_reg || last_step_reg;
    assign status.norm_done = mx_reg[23];

    logic [9:0]  sh;
    logic [31:0] packed_val;
    always_comb
    begin
        sh = 10'd1 - 10'(ex_reg);
        if (zero_reg)
            packed_val = 32'd0;
        else if (ex_reg > 10'sd0)
            packed_val = {1'b0, ex_reg[7:0], mx_reg[22:0]};
        else if (sh < 10'd32)
            packed_val = {8'd0, mx_reg[23:0]} >> sh[4:0];
        else
            packed_val = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= dividend_bits;
            y_reg <= divisor_bits;
        end
        if (cmd.unpack)
        begin
            my_reg <= uy_m;
            ey_reg <= uy_e;
            if (early)
                res_reg <= early_val;
        end
        mx_reg   <= mx_next;
        ex_reg   <= ex_next;
        zero_reg <= zero_next;
        if (cmd.pack)
            res_reg <= packed_val | {x_reg[31], 31'd0};
    end

    assign result = res_reg;

endmodule

// ===== hw/rtl/f32rem_ctrl.sv =====
// ----------------------------------------------------------------------------
// f32rem_ctrl
// Sequencer for the remainder core.
// ----------------------------------------------------------------------------
module f32rem_ctrl
    import f32rem_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  f32rem_status_t status,
    output f32rem_cmd_t    cmd
);

    f32rem_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_UNPACK;
            ST_UNPACK: state_next = status.early ? ST_OUT : ST_STEP;
            ST_STEP:   if (status.done) state_next = ST_NORM;
            ST_NORM:   if (status.norm_done) state_next = ST_PACK;
            ST_PACK:   state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_UNPACK: cmd.unpack = 1'b1;
            ST_STEP:   cmd.step   = ~status.done;
            ST_NORM:   cmd.norm   = 1'b1;
            ST_PACK:   cmd.pack   = 1'b1;
            ST_OUT:    out_valid  = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/float32_remainder_core.sv =====
// ----------------------------------------------------------------------------
// float32_remainder_core
// Exact truncated remainder of two binary32 patterns.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready channel, data = {dividend_bits, divisor_bits}.
//   out : valid/ready channel, data = remainder_bits.
// One item is processed at a time. After a transfer in, the unpack state
// unpacks and checks special cases. Invalid, equal or smaller operands
// then go straight to the output state. Otherwise the shift-subtract loop
// lowers the dividend exponent by one per step down to the divisor's, with
// a final subtract, or stops at an exact zero. Renormalisation then shifts
// out leading zeros, and the pack state packs the result. The loop runs
// through the single 26-bit subtractor.
// The result is held on the output until transferred; a stalled receiver
// holds the core and no new item is taken meanwhile.
// Reset returns the sequencer to idle; no results are pending afterwards.
// ----------------------------------------------------------------------------
module float32_remainder_core
    import f32rem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    f32rem_stream_if.sink   in_ch,
    f32rem_stream_if.source out_ch
);

    f32rem_cmd_t    cmd;
    f32rem_status_t status;

    f32rem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    f32rem_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dividend_bits (in_ch.data[63:32]),
        .divisor_bits  (in_ch.data[31:0]),
        .status        (status),
        .result        (out_ch.data)
    );

endmodule
